// ----- rtl/core/sac_pkg.sv -----
// ----------------------------------------------------------------------------
// sac_pkg
// shared widths, sideband type and saturation helper for the swept box test
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int COORD_BITS = 24;
  localparam int HALF_BITS  = COORD_BITS - 2;
  localparam int FT_W       = 32;
  localparam int RES_W      = 32;
  localparam int EXT_W      = COORD_BITS + 1;
  localparam int GAP_W      = COORD_BITS + 2;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int DIV_N      = MAG_W + FT_W;
  localparam int DVS_W      = FT_W + 1;
  localparam int WIDE_W     = DIV_N + 2;
  localparam int LAT        = DIV_N + 4;

  localparam int IN_RAW     = 6 * COORD_BITS + 4 * HALF_BITS;
  localparam int IN_W       = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW    = 5 + 4 * RES_W;
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8;

  localparam int OFS_APX    = 0;
  localparam int OFS_APY    = OFS_APX + COORD_BITS;
  localparam int OFS_PRX    = OFS_APY + COORD_BITS;
  localparam int OFS_PRY    = OFS_PRX + COORD_BITS;
  localparam int OFS_AHW    = OFS_PRY + COORD_BITS;
  localparam int OFS_AHH    = OFS_AHW + HALF_BITS;
  localparam int OFS_BPX    = OFS_AHH + HALF_BITS;
  localparam int OFS_BPY    = OFS_BPX + COORD_BITS;
  localparam int OFS_BHW    = OFS_BPY + COORD_BITS;
  localparam int OFS_BHH    = OFS_BHW + HALF_BITS;

  localparam logic [FT_W-1:0] FT_RESET = FT_W'(1092);

  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;
  localparam logic signed [1:0] NRM_ZERO = 2'sb00;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic            hit;
    logic            gx_neg;
    logic            gy_neg;
    logic            ex_neg;
    logic            ey_neg;
    logic            dx_zero;
    logic            dy_zero;
    logic            vx_neg;
    logic            vy_neg;
    logic [FT_W-1:0] ft;
  } side_t;

  function automatic logic signed [RES_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-RES_W){1'b0}}, RES_MAX});
    lo = $signed({{(WIDE_W-RES_W){1'b1}}, RES_MIN});
    if (v > hi) begin
      sat32 = RES_MAX;
    end else if (v < lo) begin
      sat32 = RES_MIN;
    end else begin
      sat32 = v[RES_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/swept_aabb_collision.sv -----
// pipeline: two front stages, one stage per quotient bit of the 57-bit dividers,
// then two back stages between input transaction and result
// throughput: one transaction per cycle; a stalled output holds the whole pipe
// reset: synchronous, clears all valid bits and sets frame_time to 1092
// ----------------------------------------------------------------------------
// swept_aabb_collision
// swept 2d box pair test with entry time, normal and velocity
// ----------------------------------------------------------------------------
module swept_aabb_collision
  import sac_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // a_pos_x, a_pos_y, a_prev_x, a_prev_y, a_half_w, a_half_h,
  // b_pos_x, b_pos_y, b_half_w, b_half_h
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // overlap, normal_x, normal_y, entry_time, remaining_time,
  // velocity_x, velocity_y, zero pad
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_we,
  input  logic [FT_W-1:0]   cfg_wdata
);

  logic [FT_W-1:0]  frame_time;
  logic [FT_W-1:0]  ft_eff;
  logic [LAT-1:0]   vld;
  logic             en;

  logic [DIV_N-1:0] dvd_ex, dvd_ey, dvd_vx, dvd_vy;
  logic [DVS_W-1:0] dvs_x, dvs_y;
  logic [DIV_N-1:0] q_ex, q_ey, q_vx, q_vy;
  side_t            side_in;
  side_t            side_d [DIV_N];

  logic                    overlap;
  logic signed [1:0]       normal_x, normal_y;
  logic signed [RES_W-1:0] entry_time, remaining_time, velocity_x, velocity_y;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT-1];
  assign ft_eff        = (frame_time == '0) ? FT_W'(1) : frame_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time <= FT_RESET;
    end else if (cfg_we) begin
      frame_time <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid};
    end
  end

  sac_front u_front (
    .clk      (clk),
    .en       (en),
    .a_pos_x  ($signed(s_axis_tdata[OFS_APX +: COORD_BITS])),
    .a_pos_y  ($signed(s_axis_tdata[OFS_APY +: COORD_BITS])),
    .a_prev_x ($signed(s_axis_tdata[OFS_PRX +: COORD_BITS])),
    .a_prev_y ($signed(s_axis_tdata[OFS_PRY +: COORD_BITS])),
    .a_half_w (s_axis_tdata[OFS_AHW +: HALF_BITS]),
    .a_half_h (s_axis_tdata[OFS_AHH +: HALF_BITS]),
    .b_pos_x  ($signed(s_axis_tdata[OFS_BPX +: COORD_BITS])),
    .b_pos_y  ($signed(s_axis_tdata[OFS_BPY +: COORD_BITS])),
    .b_half_w (s_axis_tdata[OFS_BHW +: HALF_BITS]),
    .b_half_h (s_axis_tdata[OFS_BHH +: HALF_BITS]),
    .ft       (ft_eff),
    .dvd_ex   (dvd_ex),
    .dvd_ey   (dvd_ey),
    .dvs_x    (dvs_x),
    .dvs_y    (dvs_y),
    .dvd_vx   (dvd_vx),
    .dvd_vy   (dvd_vy),
    .side     (side_in)
  );

  sac_div u_div_ex (.clk(clk), .en(en), .dvd(dvd_ex), .dvs(dvs_x), .quo(q_ex));
  sac_div u_div_ey (.clk(clk), .en(en), .dvd(dvd_ey), .dvs(dvs_y), .quo(q_ey));
  sac_div u_div_vx (.clk(clk), .en(en), .dvd(dvd_vx), .dvs(DVS_W'(side_in.ft)), .quo(q_vx));
  sac_div u_div_vy (.clk(clk), .en(en), .dvd(dvd_vy), .dvs(DVS_W'(side_in.ft)), .quo(q_vy));

  // sideband delay matching the divider depth
  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side_in;
      for (int i = 1; i < DIV_N; i++) begin
        side_d[i] <= side_d[i-1];
      end
    end
  end

  sac_back u_back (
    .clk            (clk),
    .en             (en),
    .q_ex           (q_ex),
    .q_ey           (q_ey),
    .q_vx           (q_vx),
    .q_vy           (q_vy),
    .side           (side_d[DIV_N-1]),
    .overlap        (overlap),
    .normal_x       (normal_x),
    .normal_y       (normal_y),
    .entry_time     (entry_time),
    .remaining_time (remaining_time),
    .velocity_x     (velocity_x),
    .velocity_y     (velocity_y)
  );

  assign m_axis_tdata = OUT_W'({velocity_y, velocity_x, remaining_time, entry_time,
                                normal_y, normal_x, overlap});

endmodule

// ----- rtl/core/sac_front.sv -----
// ----------------------------------------------------------------------------
// sac_front
// box extents, overlap test, gaps, then gap-times-frame products
// ----------------------------------------------------------------------------
module sac_front
  import sac_pkg::*;
(
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] a_pos_x,
  input  logic signed [COORD_BITS-1:0] a_pos_y,
  input  logic signed [COORD_BITS-1:0] a_prev_x,
  input  logic signed [COORD_BITS-1:0] a_prev_y,
  input  logic        [HALF_BITS-1:0]  a_half_w,
  input  logic        [HALF_BITS-1:0]  a_half_h,
  input  logic signed [COORD_BITS-1:0] b_pos_x,
  input  logic signed [COORD_BITS-1:0] b_pos_y,
  input  logic        [HALF_BITS-1:0]  b_half_w,
  input  logic        [HALF_BITS-1:0]  b_half_h,
  input  logic        [FT_W-1:0]       ft,
  output logic        [DIV_N-1:0]      dvd_ex,
  output logic        [DIV_N-1:0]      dvd_ey,
  output logic        [DVS_W-1:0]      dvs_x,
  output logic        [DVS_W-1:0]      dvs_y,
  output logic        [DIV_N-1:0]      dvd_vx,
  output logic        [DIV_N-1:0]      dvd_vy,
  output side_t                        side
);

  logic signed [EXT_W-1:0] aminx, amaxx, aminy, amaxy;
  logic signed [EXT_W-1:0] bminx, bmaxx, bminy, bmaxy;
  logic signed [EXT_W-1:0] ahw, ahh, bhw, bhh;
  logic signed [EXT_W-1:0] dx_c, dy_c;
  logic signed [GAP_W-1:0] gx_c, gy_c;
  logic                    hit_c;

  logic                    hit;
  logic signed [EXT_W-1:0] dx, dy;
  logic signed [GAP_W-1:0] gx, gy;
  logic        [FT_W-1:0]  ft1;

  logic signed [GAP_W-1:0] gxn, gyn;
  logic signed [EXT_W-1:0] dxn, dyn;
  logic        [MAG_W-1:0] gxm, gym;
  logic        [EXT_W-1:0] dxm, dym;

  always_comb begin
    ahw   = EXT_W'($signed({1'b0, a_half_w}));
    ahh   = EXT_W'($signed({1'b0, a_half_h}));
    bhw   = EXT_W'($signed({1'b0, b_half_w}));
    bhh   = EXT_W'($signed({1'b0, b_half_h}));
    aminx = EXT_W'(a_pos_x) - ahw;
    amaxx = EXT_W'(a_pos_x) + ahw;
    aminy = EXT_W'(a_pos_y) - ahh;
    amaxy = EXT_W'(a_pos_y) + ahh;
    bminx = EXT_W'(b_pos_x) - bhw;
    bmaxx = EXT_W'(b_pos_x) + bhw;
    bminy = EXT_W'(b_pos_y) - bhh;
    bmaxy = EXT_W'(b_pos_y) + bhh;
    hit_c = !(amaxx < bminx || bmaxx < aminx || bmaxy < aminy || amaxy < bminy);
    dx_c  = EXT_W'(a_pos_x) - EXT_W'(a_prev_x);
    dy_c  = EXT_W'(a_pos_y) - EXT_W'(a_prev_y);
    gx_c  = (dx_c > 0) ? (GAP_W'(bminx) - GAP_W'(amaxx)) : (GAP_W'(bmaxx) - GAP_W'(aminx));
    gy_c  = (dy_c > 0) ? (GAP_W'(bminy) - GAP_W'(amaxy)) : (GAP_W'(bmaxy) - GAP_W'(aminy));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_c;
      dx  <= dx_c;
      dy  <= dy_c;
      gx  <= gx_c;
      gy  <= gy_c;
      ft1 <= ft;
    end
  end

  // magnitudes for the unsigned dividers
  always_comb begin
    gxn = -gx;
    gyn = -gy;
    dxn = -dx;
    dyn = -dy;
    gxm = gx[GAP_W-1] ? gxn[MAG_W-1:0] : gx[MAG_W-1:0];
    gym = gy[GAP_W-1] ? gyn[MAG_W-1:0] : gy[MAG_W-1:0];
    dxm = dx[EXT_W-1] ? dxn : dx;
    dym = dy[EXT_W-1] ? dyn : dy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvd_ex       <= DIV_N'(gxm) * DIV_N'(ft1);
      dvd_ey       <= DIV_N'(gym) * DIV_N'(ft1);
      dvs_x        <= DVS_W'(dxm);
      dvs_y        <= DVS_W'(dym);
      dvd_vx       <= DIV_N'({dxm, 16'b0});
      dvd_vy       <= DIV_N'({dym, 16'b0});
      side.hit     <= hit;
      side.gx_neg  <= gx[GAP_W-1];
      side.gy_neg  <= gy[GAP_W-1];
      side.ex_neg  <= gx[GAP_W-1] ^ dx[EXT_W-1];
      side.ey_neg  <= gy[GAP_W-1] ^ dy[EXT_W-1];
      side.dx_zero <= (dx == '0);
      side.dy_zero <= (dy == '0);
      side.vx_neg  <= dx[EXT_W-1];
      side.vy_neg  <= dy[EXT_W-1];
      side.ft      <= ft1;
    end
  end

endmodule

// ----- rtl/core/sac_div.sv -----
// ----------------------------------------------------------------------------
// sac_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module sac_div
  import sac_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_N-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic [DIV_N-1:0] quo
);

  logic [DIV_N-1:0] num_r [DIV_N];
  logic [DIV_N-1:0] quo_r [DIV_N];
  logic [DVS_W-1:0] rem_r [DIV_N];
  logic [DVS_W-1:0] den_r [DIV_N];

  for (genvar s = 0; s < DIV_N; s++) begin : g_stage
    logic [DIV_N-1:0] num_i;
    logic [DIV_N-1:0] quo_i;
    logic [DVS_W-1:0] rem_i;
    logic [DVS_W-1:0] den_i;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    if (s == 0) begin : g_first
      assign num_i = dvd;
      assign quo_i = '0;
      assign rem_i = '0;
      assign den_i = dvs;
    end else begin : g_next
      assign num_i = num_r[s-1];
      assign quo_i = quo_r[s-1];
      assign rem_i = rem_r[s-1];
      assign den_i = den_r[s-1];
    end

    always_comb begin
      trial = {rem_i, num_i[DIV_N-1]};
      diff  = trial - {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[s] <= {num_i[DIV_N-2:0], 1'b0};
        quo_r[s] <= {quo_i[DIV_N-2:0], ~diff[DVS_W]};
        rem_r[s] <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
        den_r[s] <= den_i;
      end
    end
  end

  assign quo = quo_r[DIV_N-1];

endmodule

// ----- rtl/core/sac_back.sv -----
// ----------------------------------------------------------------------------
// sac_back
// signs, later-axis pick, normal, remaining time and saturation
// ----------------------------------------------------------------------------
module sac_back
  import sac_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [DIV_N-1:0]        q_ex,
  input  logic [DIV_N-1:0]        q_ey,
  input  logic [DIV_N-1:0]        q_vx,
  input  logic [DIV_N-1:0]        q_vy,
  input  side_t                   side,
  output logic                    overlap,
  output logic signed [1:0]       normal_x,
  output logic signed [1:0]       normal_y,
  output logic signed [RES_W-1:0] entry_time,
  output logic signed [RES_W-1:0] remaining_time,
  output logic signed [RES_W-1:0] velocity_x,
  output logic signed [RES_W-1:0] velocity_y
);

  logic signed [WIDE_W-1:0] exm, eym, vxm, vym, ex, ey;
  logic                     x_later;

  logic                     hit;
  logic signed [1:0]        nx, ny;
  logic signed [WIDE_W-1:0] et;
  logic                     et_inf;
  logic signed [RES_W-1:0]  vx, vy;
  logic [FT_W-1:0]          ft;

  logic signed [WIDE_W-1:0] rem;

  always_comb begin
    exm = $signed({2'b00, q_ex});
    eym = $signed({2'b00, q_ey});
    vxm = $signed({2'b00, q_vx});
    vym = $signed({2'b00, q_vy});
    ex  = side.ex_neg ? -exm : exm;
    ey  = side.ey_neg ? -eym : eym;
    if (side.dx_zero) begin
      x_later = 1'b0;
    end else if (side.dy_zero) begin
      x_later = 1'b1;
    end else begin
      x_later = (ex > ey);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit    <= side.hit;
      nx     <= x_later ? (side.gx_neg ? NRM_POS : NRM_NEG) : NRM_ZERO;
      ny     <= x_later ? NRM_ZERO : (side.gy_neg ? NRM_POS : NRM_NEG);
      et     <= x_later ? ex : ey;
      et_inf <= !x_later && side.dy_zero;
      vx     <= sat32(side.vx_neg ? -vxm : vxm);
      vy     <= sat32(side.vy_neg ? -vym : vym);
      ft     <= side.ft;
    end
  end

  assign rem = $signed({{(WIDE_W-FT_W){1'b0}}, ft}) - et;

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= hit;
      if (!hit) begin
        normal_x       <= NRM_ZERO;
        normal_y       <= NRM_ZERO;
        entry_time     <= '0;
        remaining_time <= '0;
        velocity_x     <= '0;
        velocity_y     <= '0;
      end else begin
        normal_x       <= nx;
        normal_y       <= ny;
        entry_time     <= et_inf ? RES_MIN : sat32(et);
        remaining_time <= et_inf ? RES_MAX : sat32(rem);
        velocity_x     <= vx;
        velocity_y     <= vy;
      end
    end
  end

endmodule

// ----- rtl/core/sac_chk.sv -----
// ----------------------------------------------------------------------------
// sac_chk
// port-level checks on the swept box test results
// ----------------------------------------------------------------------------
module sac_chk
  import sac_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  logic       ov;
  logic [1:0] nx, ny;

  assign ov = m_axis_tdata[0];
  assign nx = m_axis_tdata[2:1];
  assign ny = m_axis_tdata[4:3];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !ov |-> m_axis_tdata[OUT_W-1:1] == '0)
    else $error("miss result carries non-zero fields");

  a_one_normal: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ov |-> ((nx == 2'b00) != (ny == 2'b00)) && nx != 2'b10 && ny != 2'b10)
    else $error("bad impact normal");

  a_inf_rem: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && ov && m_axis_tdata[36:5] == 32'h80000000 && ny != 2'b00
      |-> m_axis_tdata[68:37] == 32'h7fffffff)
    else $error("minus infinity entry without full remaining time");

endmodule

bind swept_aabb_collision sac_chk u_sac_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
